// ----- src/swtv_pkg.sv -----
// swtv_pkg: shared types for the sliding window type voter.
// No dependencies; used by sliding_window_type_voter.
package swtv_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_OLD,
		ST_DEC,
		ST_SCAN,
		ST_EMIT
	} state_t;

	localparam int unsigned CLASS_FIELD_W = 4;
	localparam int unsigned TDATA_W       = 8;

endpackage

// ----- src/swtv_ram.sv -----
// swtv_ram: single-port-write, single-port-read synchronous RAM with a registered read port.
// Holds the class window; contents undefined until written. No dependencies.
module swtv_ram #(
	parameter int unsigned DEPTH = 15,
	parameter int unsigned WIDTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	assign rdata = rdata_s1;

endmodule

// ----- src/swtv_vote_ram.sv -----
// swtv_vote_ram: vote counter RAM with per-entry valid bits; an unwritten entry reads zero.
// Registered read, read-before-write. No dependencies.
module swtv_vote_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] mem_s1;
	logic [DEPTH-1:0] valid_q;
	logic             valid_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		mem_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			valid_s1 <= valid_q[raddr];
		end
	end

	assign rdata = valid_s1 ? mem_s1 : '0;

endmodule

// ----- src/sliding_window_type_voter.sv -----
// Sliding window type voter: smooths an object's class label by a majority vote over a window
// of recent seen frames. Depends on swtv_pkg, swtv_ram, swtv_vote_ram.
//
// One input transfer gives exactly one output transfer. A seen frame first does a
// read-modify-write on the window and vote RAMs in states READ, OLD and DEC, then a scan of
// all NUM_CLASSES vote counters through the single read port of the vote RAM (one counter
// per cycle), then the output load. Items are processed one at a time; the output register
// lets the next item enter while a result waits to be taken. No clearing pass is needed
// after reset.
module sliding_window_type_voter #(
	parameter int unsigned NUM_CLASSES = 16,
	parameter int unsigned WINDOW_LEN  = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [3:0] observed_class, [7:4] zero
	input  logic       s_tuser,  // [0] seen
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [3:0] voted_class, [7:4] zero
);

	localparam int unsigned CLS_W  = $clog2(NUM_CLASSES);
	localparam int unsigned SLOT_W = $clog2(WINDOW_LEN);
	localparam int unsigned CNT_W  = $clog2(WINDOW_LEN + 1);
	localparam int unsigned AGE_W  = $clog2(WINDOW_LEN + 2);
	localparam int unsigned SCAN_W = CLS_W + 1;
	localparam int unsigned EXT_W  = CLS_W + swtv_pkg::CLASS_FIELD_W;

	swtv_pkg::state_t state_q, state_d;

	logic [AGE_W-1:0]  age_q;
	logic [SLOT_W-1:0] sp_q;
	logic [SLOT_W-1:0] sp_next;
	logic              warm_now;
	logic              accept;

	logic [CLS_W-1:0]  cls_q;
	logic [SLOT_W-1:0] slot_q;
	logic              warm_q;
	logic [CLS_W-1:0]  old_q;
	logic              repl_q;
	logic [CLS_W-1:0]  chosen_q;

	logic [SCAN_W-1:0] scan_q;
	logic              rd_vld_s1;
	logic [CLS_W-1:0]  rd_idx_s1;
	logic [CLS_W-1:0]  best_idx_q;
	logic [CNT_W-1:0]  best_cnt_q;
	logic              cand_better;
	logic              scan_last;

	logic              out_valid_q;
	logic [swtv_pkg::CLASS_FIELD_W-1:0] out_class_q;

	logic [EXT_W-1:0]  cls_ext;
	logic [CLS_W-1:0]  cls_in;
	logic [EXT_W-1:0]  chosen_ext;
	logic              out_free;

	logic              win_we;
	logic [CLS_W-1:0]  win_rdata;
	logic              vote_we;
	logic [CLS_W-1:0]  vote_waddr;
	logic [CNT_W-1:0]  vote_wdata;
	logic [CLS_W-1:0]  vote_raddr;
	logic [CNT_W-1:0]  vote_rdata;
	logic              repl_now;
	logic              scan_issue;

	assign cls_ext = {{CLS_W{1'b0}}, s_tdata[swtv_pkg::CLASS_FIELD_W-1:0]};
	assign cls_in  = (cls_ext >= EXT_W'(NUM_CLASSES)) ?
			CLS_W'(NUM_CLASSES - 1) : cls_ext[CLS_W-1:0];

	assign accept   = s_tvalid && s_tready;
	assign sp_next  = (sp_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : sp_q + 1'b1;
	assign warm_now = age_q < AGE_W'(WINDOW_LEN);
	assign out_free = !out_valid_q || m_tready;
	assign repl_now = warm_q || (win_rdata != cls_q);
	assign scan_issue = (state_q == swtv_pkg::ST_SCAN) && (scan_q < SCAN_W'(NUM_CLASSES));
	assign cand_better = (rd_idx_s1 == '0) || (vote_rdata > best_cnt_q);
	assign scan_last   = rd_vld_s1 && (rd_idx_s1 == CLS_W'(NUM_CLASSES - 1));

	swtv_ram #(
		.DEPTH(WINDOW_LEN),
		.WIDTH(CLS_W)
	) u_win (
		.clk  (clk),
		.we   (win_we),
		.waddr(slot_q),
		.wdata(cls_q),
		.raddr(slot_q),
		.rdata(win_rdata)
	);

	swtv_vote_ram #(
		.DEPTH(NUM_CLASSES),
		.WIDTH(CNT_W)
	) u_votes (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (vote_we),
		.waddr (vote_waddr),
		.wdata (vote_wdata),
		.raddr (vote_raddr),
		.rdata (vote_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			swtv_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = s_tuser ? swtv_pkg::ST_READ : swtv_pkg::ST_EMIT;
				end
			end
			swtv_pkg::ST_READ: state_d = swtv_pkg::ST_OLD;
			swtv_pkg::ST_OLD:  state_d = swtv_pkg::ST_DEC;
			swtv_pkg::ST_DEC:  state_d = swtv_pkg::ST_SCAN;
			swtv_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = swtv_pkg::ST_EMIT;
				end
			end
			swtv_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = swtv_pkg::ST_IDLE;
				end
			end
			default: state_d = swtv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		win_we     = 1'b0;
		vote_we    = 1'b0;
		vote_waddr = cls_q;
		vote_wdata = vote_rdata + 1'b1;
		vote_raddr = cls_q;
		case (state_q)
			swtv_pkg::ST_IDLE: s_tready = 1'b1;
			swtv_pkg::ST_OLD: begin
				win_we  = repl_now;
				vote_we = repl_now;
				if (!warm_q) begin
					vote_raddr = win_rdata;
				end
			end
			swtv_pkg::ST_DEC: begin
				vote_we    = !warm_q && repl_q && (vote_rdata != '0);
				vote_waddr = old_q;
				vote_wdata = vote_rdata - 1'b1;
			end
			swtv_pkg::ST_SCAN: vote_raddr = scan_q[CLS_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swtv_pkg::ST_IDLE;
			age_q       <= '0;
			sp_q        <= '0;
			chosen_q    <= '0;
			scan_q      <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue;
			if (accept && s_tuser) begin
				if (age_q < AGE_W'(WINDOW_LEN + 1)) begin
					age_q <= age_q + 1'b1;
				end
				sp_q <= sp_next;
			end
			if (state_q == swtv_pkg::ST_DEC) begin
				scan_q <= '0;
			end else if (scan_issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (state_q == swtv_pkg::ST_SCAN && scan_last) begin
				chosen_q <= cand_better ? rd_idx_s1 : best_idx_q;
			end
			if (state_q == swtv_pkg::ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign chosen_ext = {{swtv_pkg::CLASS_FIELD_W{1'b0}}, chosen_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			cls_q  <= cls_in;
			warm_q <= warm_now;
			slot_q <= warm_now ? sp_q : sp_next;
		end
		if (state_q == swtv_pkg::ST_OLD) begin
			old_q  <= win_rdata;
			repl_q <= repl_now;
		end
		rd_idx_s1 <= scan_q[CLS_W-1:0];
		if (rd_vld_s1 && cand_better) begin
			best_idx_q <= rd_idx_s1;
			best_cnt_q <= vote_rdata;
		end
		if (state_q == swtv_pkg::ST_EMIT && out_free) begin
			out_class_q <= chosen_ext[swtv_pkg::CLASS_FIELD_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(swtv_pkg::TDATA_W - swtv_pkg::CLASS_FIELD_W){1'b0}}, out_class_q};

	a_age_bound: assert property (@(posedge clk) disable iff (!arst_n)
		age_q <= AGE_W'(WINDOW_LEN + 1))
		else $error("age count past saturation");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q < SLOT_W'(WINDOW_LEN))
		else $error("slot pointer out of window");

	a_inc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swtv_pkg::ST_OLD && vote_we) |-> vote_wdata != '0)
		else $error("vote counter overflow on increment");

	a_dec_other: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swtv_pkg::ST_DEC && vote_we) |-> (old_q != cls_q && !warm_q))
		else $error("decrement of the incoming class");

	a_scan_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swtv_pkg::ST_SCAN && scan_last) |=> state_q == swtv_pkg::ST_EMIT)
		else $error("scan end without result load");

endmodule
